@@ hdl/kbd_xlat_pkg.sv @@
// Package: scan code constants and the three character lookup tables.
package kbd_xlat_pkg;

   localparam logic [7:0] SC_SHIFT_DOWN = 8'h70;
   localparam logic [7:0] SC_SHIFT_UP   = 8'hF0;
   localparam logic [7:0] SC_CAPS_ON    = 8'h71;
   localparam logic [7:0] SC_CAPS_OFF   = 8'hF1;
   localparam logic [7:0] SC_CTRL_DOWN  = 8'h74;
   localparam logic [7:0] SC_CTRL_UP    = 8'hF4;
   localparam logic [7:0] SC_MOD_MASK   = 8'h70;
   localparam logic [7:0] SC_RELEASE    = 8'h80;

   typedef enum logic [1:0] {
      TAB_NORMAL,
      TAB_SHIFT,
      TAB_CTRL
   } tab_sel_type;

   // numeric keypad, common to all three tables
   function automatic logic [7:0] keypad_char(input logic [3:0] k);
      logic [7:0] c;
      case (k)
         4'h0: c = 8'h2D;  4'h1: c = 8'h2F;  4'h2: c = 8'h37;  4'h3: c = 8'h38;
         4'h4: c = 8'h39;  4'h5: c = 8'h2A;  4'h6: c = 8'h34;  4'h7: c = 8'h35;
         4'h8: c = 8'h36;  4'h9: c = 8'h2B;  4'hA: c = 8'h31;  4'hB: c = 8'h32;
         4'hC: c = 8'h33;  4'hD: c = 8'h3D;  4'hE: c = 8'h30;  4'hF: c = 8'h2C;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] normal_char(input logic [6:0] i);
      logic [7:0] c;
      case (i)
         7'h01: c = 8'h31;  7'h02: c = 8'h32;  7'h03: c = 8'h33;  7'h04: c = 8'h34;
         7'h05: c = 8'h35;  7'h06: c = 8'h36;  7'h07: c = 8'h37;  7'h08: c = 8'h38;
         7'h09: c = 8'h39;  7'h0A: c = 8'h30;  7'h0B: c = 8'h2D;  7'h0C: c = 8'h5E;
         7'h0D: c = 8'h5C;  7'h0E: c = 8'h08;  7'h0F: c = 8'h09;
         7'h10: c = 8'h71;  7'h11: c = 8'h77;  7'h12: c = 8'h65;  7'h13: c = 8'h72;
         7'h14: c = 8'h74;  7'h15: c = 8'h79;  7'h16: c = 8'h75;  7'h17: c = 8'h69;
         7'h18: c = 8'h6F;  7'h19: c = 8'h70;  7'h1A: c = 8'h40;  7'h1B: c = 8'h5B;
         7'h1C: c = 8'h0A;  7'h1D: c = 8'h61;  7'h1E: c = 8'h73;  7'h1F: c = 8'h64;
         7'h20: c = 8'h66;  7'h21: c = 8'h67;  7'h22: c = 8'h68;  7'h23: c = 8'h6A;
         7'h24: c = 8'h6B;  7'h25: c = 8'h6C;  7'h26: c = 8'h3B;  7'h27: c = 8'h3A;
         7'h28: c = 8'h5D;  7'h29: c = 8'h7A;  7'h2A: c = 8'h78;  7'h2B: c = 8'h63;
         7'h2C: c = 8'h76;  7'h2D: c = 8'h62;  7'h2E: c = 8'h6E;  7'h2F: c = 8'h6D;
         7'h30: c = 8'h2C;  7'h31: c = 8'h2E;  7'h32: c = 8'h2F;  7'h33: c = 8'h5F;
         7'h34: c = 8'h20;  7'h39: c = 8'hFF;
         default: c = (i[6:4] == 3'h4) ? keypad_char(i[3:0]) : 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] shift_char(input logic [6:0] i);
      logic [7:0] c;
      case (i)
         7'h01: c = 8'h21;  7'h02: c = 8'h22;  7'h03: c = 8'h23;  7'h04: c = 8'h24;
         7'h05: c = 8'h25;  7'h06: c = 8'h26;  7'h07: c = 8'h27;  7'h08: c = 8'h28;
         7'h09: c = 8'h29;  7'h0B: c = 8'h3D;  7'h0C: c = 8'h60;
         7'h0D: c = 8'h7C;  7'h0E: c = 8'h08;  7'h0F: c = 8'h09;
         7'h10: c = 8'h51;  7'h11: c = 8'h57;  7'h12: c = 8'h45;  7'h13: c = 8'h52;
         7'h14: c = 8'h54;  7'h15: c = 8'h59;  7'h16: c = 8'h55;  7'h17: c = 8'h49;
         7'h18: c = 8'h4F;  7'h19: c = 8'h50;  7'h1A: c = 8'h7E;  7'h1B: c = 8'h7B;
         7'h1C: c = 8'h0A;  7'h1D: c = 8'h41;  7'h1E: c = 8'h53;  7'h1F: c = 8'h44;
         7'h20: c = 8'h46;  7'h21: c = 8'h47;  7'h22: c = 8'h48;  7'h23: c = 8'h4A;
         7'h24: c = 8'h4B;  7'h25: c = 8'h4C;  7'h26: c = 8'h2B;  7'h27: c = 8'h2A;
         7'h28: c = 8'h5D;  7'h29: c = 8'h5A;  7'h2A: c = 8'h58;  7'h2B: c = 8'h43;
         7'h2C: c = 8'h56;  7'h2D: c = 8'h42;  7'h2E: c = 8'h4E;  7'h2F: c = 8'h4D;
         7'h30: c = 8'h3C;  7'h31: c = 8'h3E;  7'h32: c = 8'h3F;  7'h33: c = 8'h5F;
         7'h34: c = 8'h20;  7'h39: c = 8'hFF;
         default: c = (i[6:4] == 3'h4) ? keypad_char(i[3:0]) : 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] ctrl_char(input logic [6:0] i);
      logic [7:0] c;
      case (i)
         7'h0E: c = 8'h08;  7'h0F: c = 8'h09;
         7'h10: c = 8'h11;  7'h11: c = 8'h17;  7'h12: c = 8'h05;  7'h13: c = 8'h12;
         7'h14: c = 8'h14;  7'h15: c = 8'h19;  7'h16: c = 8'h15;  7'h17: c = 8'h09;
         7'h18: c = 8'h0F;  7'h19: c = 8'h10;  7'h1A: c = 8'h00;  7'h1B: c = 8'h1B;
         7'h1C: c = 8'h0A;  7'h1D: c = 8'h01;  7'h1E: c = 8'h13;  7'h1F: c = 8'h04;
         7'h20: c = 8'h06;  7'h21: c = 8'h07;  7'h22: c = 8'h08;  7'h23: c = 8'h0A;
         7'h24: c = 8'h0B;  7'h25: c = 8'h0C;  7'h26: c = 8'h1B;  7'h27: c = 8'h1A;
         7'h28: c = 8'h1D;  7'h29: c = 8'h1A;  7'h2A: c = 8'h18;  7'h2B: c = 8'h03;
         7'h2C: c = 8'h16;  7'h2D: c = 8'h02;  7'h2E: c = 8'h0E;  7'h2F: c = 8'h0D;
         default: c = (i[6:4] == 3'h4) ? keypad_char(i[3:0]) : 8'h00;
      endcase
      return c;
   endfunction

endpackage

@@ hdl/keyboard_scan_code_translator_core.sv @@
// Keyboard scan code translator: one scan code beat in, up to two result beats out.
//
// Takes one scan code per beat and returns the translated character, preceded by
// the untranslated code when raw mode is set (tuser high marks that raw beat; tlast
// marks the final beat for the code). Shift, control and caps-lock presses and
// releases update the held flags and yield no character. A code is accepted in
// any cycle in which the one-entry holding register is free or about to drain, so
// one code per cycle is sustained while each code yields at most one result and
// the output is not stalled; a code with a raw beat and a character holds off the
// next until its raw beat moves from the holding to the single result register.
// Raw mode is to be written only while idle; the block does not enforce this.
module keyboard_scan_code_translator_core
   import kbd_xlat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] code
   output logic       rsp_tuser,   // [0] is_raw
   output logic       rsp_tlast,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data     // [0] raw_mode
);

   logic       raw_mode_ff, raw_mode_in;
   logic       shift_ff, shift_in;
   logic       ctrl_ff, ctrl_in;
   logic       caps_ff, caps_in;

   logic       hold_raw_ff, hold_raw_in;
   logic       hold_chr_ff, hold_chr_in;
   logic [7:0] hold_sc_ff, hold_sc_in;
   logic [7:0] hold_ch_ff, hold_ch_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_code_ff, out_code_in;
   logic       out_raw_ff, out_raw_in;
   logic       out_last_ff, out_last_in;

   logic        accept, out_free, hold_one, hold_empty;
   logic        is_mod, is_rel;
   logic [6:0]  idx;
   logic [7:0]  ch;
   tab_sel_type sel;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign hold_empty = !hold_raw_ff && !hold_chr_ff;
   assign hold_one   = hold_raw_ff ^ hold_chr_ff;
   assign req_tready = hold_empty || (out_free && hold_one);
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_code_ff;
   assign rsp_tuser  = out_raw_ff;
   assign rsp_tlast  = out_last_ff;

   assign is_mod = (req_tdata & SC_MOD_MASK) == SC_MOD_MASK;
   assign is_rel = (req_tdata & SC_RELEASE) != 8'h00;
   assign idx    = req_tdata[6:0];

   always_comb begin
      if (ctrl_ff) begin
         sel = TAB_CTRL;
      end else if (caps_ff != shift_ff) begin
         sel = TAB_SHIFT;
      end else begin
         sel = TAB_NORMAL;
      end
      ch = 8'h00;
      if (!is_mod && !is_rel) begin
         case (sel)
            TAB_CTRL:  ch = ctrl_char(idx);
            TAB_SHIFT: ch = shift_char(idx);
            default:   ch = normal_char(idx);
         endcase
      end
   end

   always_comb begin
      raw_mode_in  = raw_mode_ff;
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      caps_in      = caps_ff;
      hold_raw_in  = hold_raw_ff;
      hold_chr_in  = hold_chr_ff;
      hold_sc_in   = hold_sc_ff;
      hold_ch_in   = hold_ch_ff;
      out_valid_in = out_valid_ff;
      out_code_in  = out_code_ff;
      out_raw_in   = out_raw_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) begin
         raw_mode_in = csr_data;
      end

      // drain the holding register, raw beat first
      if (out_free) begin
         if (hold_raw_ff) begin
            out_valid_in = 1'b1;
            out_code_in  = hold_sc_ff;
            out_raw_in   = 1'b1;
            out_last_in  = !hold_chr_ff;
            hold_raw_in  = 1'b0;
         end else if (hold_chr_ff) begin
            out_valid_in = 1'b1;
            out_code_in  = hold_ch_ff;
            out_raw_in   = 1'b0;
            out_last_in  = 1'b1;
            hold_chr_in  = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end

      if (accept) begin
         hold_raw_in = raw_mode_ff;
         hold_chr_in = ch != 8'h00;
         hold_sc_in  = req_tdata;
         hold_ch_in  = ch;
         case (req_tdata)
            SC_SHIFT_DOWN: shift_in = 1'b1;
            SC_SHIFT_UP:   shift_in = 1'b0;
            SC_CTRL_DOWN:  ctrl_in  = 1'b1;
            SC_CTRL_UP:    ctrl_in  = 1'b0;
            SC_CAPS_ON:    caps_in  = 1'b1;
            SC_CAPS_OFF:   caps_in  = 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff  <= 1'b0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         caps_ff      <= 1'b0;
         hold_raw_ff  <= 1'b0;
         hold_chr_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         raw_mode_ff  <= raw_mode_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         caps_ff      <= caps_in;
         hold_raw_ff  <= hold_raw_in;
         hold_chr_ff  <= hold_chr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_sc_ff  <= hold_sc_in;
      hold_ch_ff  <= hold_ch_in;
      out_code_ff <= out_code_in;
      out_raw_ff  <= out_raw_in;
      out_last_ff <= out_last_in;
   end

endmodule

@@ hdl/kbd_xlat_checker.sv @@
// Port-level checker for the scan code translator, bound to the top level.
module kbd_xlat_props (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a raw beat that is not last is followed at once by its character
   a_raw_then_chr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && !rsp_tlast |=> rsp_tvalid && !rsp_tuser)
      else $error("character missing after non-final raw beat");

   // characters are never zero and always close the run
   a_chr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata != 8'h00)
      else $error("bad character beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind keyboard_scan_code_translator_core kbd_xlat_props u_kbd_xlat_props (.*);
